FILE: rtl/smmc3_pkg.sv
// ----------------------------------------------------------------------------
// smmc3_pkg
// shared constants, codes and types of the scrambled mmc3 bank mapper
// ----------------------------------------------------------------------------
package smmc3_pkg;

   localparam int BANK_WIDTH       = 8;
   localparam int NUM_BANK_REGS    = 8;
   localparam int BANK_INDEX_WIDTH = $clog2(NUM_BANK_REGS);
   localparam int RESET_ONE_ENTRY  = 7;
   localparam int MOD_STEP_WIDTH   = $clog2(BANK_WIDTH);
   localparam int ADDR_WIDTH       = 16;
   localparam int PRG_SLOTS        = 4;
   localparam int CHR_SLOTS        = 8;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRG_COUNT    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHR_COUNT    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIXED_MIRROR = 2'd2;
   localparam logic [BANK_WIDTH-1:0]      PRG_COUNT_RESET  = 8'd2;

   // item kinds
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // cpu address decode
   localparam logic [ADDR_WIDTH-1:0] BANK_WIN_LO      = 16'h8000;
   localparam logic [ADDR_WIDTH-1:0] BANK_WIN_HI      = 16'h9FFF;
   localparam logic [ADDR_WIDTH-1:0] ADDR_DECODE_MASK = 16'hE001;
   localparam logic [ADDR_WIDTH-1:0] DEC_MIRROR       = 16'hA000;
   localparam logic [ADDR_WIDTH-1:0] DEC_IRQ_LATCH    = 16'hC000;
   localparam logic [ADDR_WIDTH-1:0] DEC_IRQ_RELOAD   = 16'hC001;
   localparam logic [ADDR_WIDTH-1:0] DEC_IRQ_DISABLE  = 16'hE000;
   localparam logic [ADDR_WIDTH-1:0] DEC_IRQ_ENABLE   = 16'hE001;

   localparam logic [BANK_WIDTH-1:0] CHR_EVEN_MASK = 8'hFE;
   localparam logic [BANK_WIDTH-1:0] CHR_ODD_BIT   = 8'h01;

   // operands reduced in turn by the shared modulo unit
   localparam int NUM_OPERANDS     = 10;
   localparam int OP_INDEX_WIDTH   = $clog2(NUM_OPERANDS);
   localparam logic [OP_INDEX_WIDTH-1:0] OP_PRG_R6   = 4'd0;
   localparam logic [OP_INDEX_WIDTH-1:0] OP_PRG_R7   = 4'd1;
   localparam logic [OP_INDEX_WIDTH-1:0] OP_CHR_LO0  = 4'd2;
   localparam logic [OP_INDEX_WIDTH-1:0] OP_CHR_LO1  = 4'd3;
   localparam logic [OP_INDEX_WIDTH-1:0] OP_CHR_LO2  = 4'd4;
   localparam logic [OP_INDEX_WIDTH-1:0] OP_CHR_LO3  = 4'd5;
   localparam logic [OP_INDEX_WIDTH-1:0] OP_CHR_HI0  = 4'd6;
   localparam logic [OP_INDEX_WIDTH-1:0] OP_CHR_HI1  = 4'd7;
   localparam logic [OP_INDEX_WIDTH-1:0] OP_CHR_HI2  = 4'd8;
   localparam logic [OP_INDEX_WIDTH-1:0] OP_CHR_HI3  = 4'd9;
   localparam logic [OP_INDEX_WIDTH-1:0] OP_LAST     = 4'd9;

   typedef struct packed {
      logic                  func;
      logic [ADDR_WIDTH-1:0] address;
      logic [BANK_WIDTH-1:0] data;
      logic                  rendering_on;
   } item_type;

   typedef struct packed {
      logic mirror_set;
      logic irq_raise;
      logic irq_clear;
   } flags_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_START  = 4'b0010,
      ST_WAIT   = 4'b0100,
      ST_FINISH = 4'b1000
   } seq_state_type;

   // scrambled bank select
   function automatic logic [BANK_INDEX_WIDTH-1:0] sel_perm(
      input logic [BANK_INDEX_WIDTH-1:0] s);
      logic [BANK_INDEX_WIDTH-1:0] r;
      case (s)
         3'd0:    r = 3'd0;
         3'd1:    r = 3'd3;
         3'd2:    r = 3'd1;
         3'd3:    r = 3'd5;
         3'd4:    r = 3'd6;
         3'd5:    r = 3'd7;
         3'd6:    r = 3'd2;
         default: r = 3'd4;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/smmc3_req_if.sv
// ----------------------------------------------------------------------------
// smmc3_req_if
// request channel: cpu write or scanline tick beats
// ----------------------------------------------------------------------------
interface smmc3_req_if;
   logic                                      valid;
   logic                                      ready;
   logic                                      func;
   logic [smmc3_pkg::ADDR_WIDTH-1:0]          address;
   logic [smmc3_pkg::BANK_WIDTH-1:0]          data;
   logic                                      rendering_on;

   modport source (output valid, func, address, data, rendering_on, input ready);
   modport sink   (input valid, func, address, data, rendering_on, output ready);
endinterface

FILE: rtl/smmc3_rsp_if.sv
// ----------------------------------------------------------------------------
// smmc3_rsp_if
// response channel: bank maps and status beats
// ----------------------------------------------------------------------------
interface smmc3_rsp_if;
   logic                                                    valid;
   logic                                                    ready;
   logic [smmc3_pkg::PRG_SLOTS*smmc3_pkg::BANK_WIDTH-1:0]   prg_map;
   logic [smmc3_pkg::CHR_SLOTS*smmc3_pkg::BANK_WIDTH-1:0]   chr_map;
   logic                                                    chr_mapped;
   logic                                                    mirror_horizontal;
   logic                                                    mirror_set;
   logic                                                    irq_raise;
   logic                                                    irq_clear;

   modport source (output valid, prg_map, chr_map, chr_mapped, mirror_horizontal,
                   mirror_set, irq_raise, irq_clear, input ready);
   modport sink   (input valid, prg_map, chr_map, chr_mapped, mirror_horizontal,
                   mirror_set, irq_raise, irq_clear, output ready);
endinterface

FILE: rtl/smmc3_mod_unit.sv
// ----------------------------------------------------------------------------
// smmc3_mod_unit
// bit-serial restoring remainder, one dividend bit per cycle
// ----------------------------------------------------------------------------
module smmc3_mod_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [smmc3_pkg::BANK_WIDTH-1:0] dividend,
   input  logic [smmc3_pkg::BANK_WIDTH-1:0] divisor,
   output logic                             done,
   output logic [smmc3_pkg::BANK_WIDTH-1:0] remainder
);

   localparam logic [smmc3_pkg::MOD_STEP_WIDTH-1:0] LAST_STEP =
      smmc3_pkg::MOD_STEP_WIDTH'(smmc3_pkg::BANK_WIDTH - 1);

   logic                                   busy_ff;
   logic                                   done_ff;
   logic [smmc3_pkg::MOD_STEP_WIDTH-1:0]   step_ff;
   logic [smmc3_pkg::BANK_WIDTH-1:0]       rem_ff;
   logic [smmc3_pkg::BANK_WIDTH-1:0]       rem_in;
   logic [smmc3_pkg::BANK_WIDTH-1:0]       dvd_ff;
   logic [smmc3_pkg::BANK_WIDTH-1:0]       dvs_ff;
   logic [smmc3_pkg::BANK_WIDTH:0]         trial;
   logic [smmc3_pkg::BANK_WIDTH:0]         dvs_ext;

   // a zero divisor subtracts nothing, so the dividend passes through unreduced
   always_comb begin
      trial   = {rem_ff, dvd_ff[smmc3_pkg::BANK_WIDTH-1]};
      dvs_ext = {1'b0, dvs_ff};
      if (trial >= dvs_ext) begin
         rem_in = smmc3_pkg::BANK_WIDTH'(trial - dvs_ext);
      end else begin
         rem_in = trial[smmc3_pkg::BANK_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            rem_ff  <= '0;
            dvd_ff  <= dividend;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            dvd_ff  <= {dvd_ff[smmc3_pkg::BANK_WIDTH-2:0], 1'b0};
            step_ff <= step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/smmc3_state.sv
// ----------------------------------------------------------------------------
// smmc3_state
// mapper register file, cpu write decode and scanline irq counter
// ----------------------------------------------------------------------------
module smmc3_state (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             apply,
   input  smmc3_pkg::item_type              item,
   input  logic                             fixed_mirror,
   output logic [smmc3_pkg::BANK_WIDTH-1:0] bank_regs [smmc3_pkg::NUM_BANK_REGS],
   output logic [smmc3_pkg::BANK_WIDTH-1:0] select_reg,
   output logic                             mirror_bit,
   output smmc3_pkg::flags_type             flags
);

   logic [smmc3_pkg::BANK_WIDTH-1:0] bank_ff [smmc3_pkg::NUM_BANK_REGS];
   logic [smmc3_pkg::BANK_WIDTH-1:0] select_ff, select_in;
   logic                             mirror_ff, mirror_in;
   logic [smmc3_pkg::BANK_WIDTH-1:0] latch_ff, latch_in;
   logic [smmc3_pkg::BANK_WIDTH-1:0] count_ff, count_in;
   logic                             reload_ff, reload_in;
   logic                             enable_ff, enable_in;
   logic                             bank_we;
   logic [smmc3_pkg::BANK_INDEX_WIDTH-1:0] bank_idx;
   logic [smmc3_pkg::ADDR_WIDTH-1:0]  decoded;
   smmc3_pkg::flags_type              flags_in;

   always_comb begin
      select_in = select_ff;
      mirror_in = mirror_ff;
      latch_in  = latch_ff;
      count_in  = count_ff;
      reload_in = reload_ff;
      enable_in = enable_ff;
      bank_we   = 1'b0;
      bank_idx  = smmc3_pkg::sel_perm(select_ff[smmc3_pkg::BANK_INDEX_WIDTH-1:0]);
      flags_in  = '0;
      decoded   = item.address & smmc3_pkg::ADDR_DECODE_MASK;
      if (item.func == smmc3_pkg::FUNC_WRITE) begin
         if (item.address >= smmc3_pkg::BANK_WIN_LO &&
             item.address <= smmc3_pkg::BANK_WIN_HI) begin
            if (item.address[0]) begin
               bank_we = 1'b1;
            end else begin
               select_in = item.data;
            end
         end else begin
            case (decoded)
               smmc3_pkg::DEC_MIRROR: begin
                  mirror_in           = item.data[0];
                  flags_in.mirror_set = ~fixed_mirror;
               end
               smmc3_pkg::DEC_IRQ_LATCH:  latch_in  = item.data;
               smmc3_pkg::DEC_IRQ_RELOAD: reload_in = 1'b1;
               smmc3_pkg::DEC_IRQ_DISABLE: begin
                  enable_in          = 1'b0;
                  flags_in.irq_clear = 1'b1;
               end
               smmc3_pkg::DEC_IRQ_ENABLE: enable_in = 1'b1;
               default: ;
            endcase
         end
      end else if (item.rendering_on) begin
         if (count_ff == '0 || reload_ff) begin
            count_in = latch_ff;
         end else begin
            count_in = count_ff - 1'b1;
         end
         flags_in.irq_raise = (count_in == '0) && enable_ff;
         reload_in          = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < smmc3_pkg::NUM_BANK_REGS; i++) begin
            bank_ff[i] <= '0;
         end
         bank_ff[smmc3_pkg::RESET_ONE_ENTRY] <= smmc3_pkg::BANK_WIDTH'(1);
         select_ff <= '0;
         mirror_ff <= 1'b0;
         latch_ff  <= '0;
         count_ff  <= '0;
         reload_ff <= 1'b0;
         enable_ff <= 1'b0;
      end else if (apply) begin
         if (bank_we) begin
            bank_ff[bank_idx] <= item.data;
         end
         select_ff <= select_in;
         mirror_ff <= mirror_in;
         latch_ff  <= latch_in;
         count_ff  <= count_in;
         reload_ff <= reload_in;
         enable_ff <= enable_in;
      end
   end

   assign bank_regs  = bank_ff;
   assign select_reg = select_ff;
   assign mirror_bit = mirror_ff;
   assign flags      = flags_in;

endmodule

FILE: rtl/scrambled_mmc3_bank_mapper.sv
// ----------------------------------------------------------------------------
// scrambled_mmc3_bank_mapper
// mmc3-style bank mapper with scrambled bank select and shared modulo unit
// ----------------------------------------------------------------------------
//  channel  | dir | handshake              | beat contents
//  ---------+-----+------------------------+---------------------------------
//  req      | in  | valid / ready          | func, address, data, rendering_on
//  rsp      | out | valid / ready          | prg/chr maps, mirroring, irq flags
//  csr      | in  | write enable, no wait  | index, write data (8 bits)
//
//  a request beat is taken while idle; ten bank numbers then go one
//  after the other through the bit-serial modulo unit (load, 8 bit steps,
//  result), then the finish state packs the response, holding while the
//  previous response beat still waits, and the sequencer returns to idle
//  req.ready is high only while the sequencer is idle; the response register
//  lets the next request in while a response beat still waits on rsp.ready
//  reset (synchronous) restores all mapper state and the csr defaults
// ----------------------------------------------------------------------------
module scrambled_mmc3_bank_mapper (
   input  logic                                  clock,
   input  logic                                  reset,
   smmc3_req_if.sink                             req,
   smmc3_rsp_if.source                           rsp,
   input  logic                                  csr_write_enable,
   input  logic [smmc3_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [smmc3_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   localparam int BW = smmc3_pkg::BANK_WIDTH;

   // configuration registers
   logic [BW-1:0] prg_count_ff;
   logic [BW-1:0] chr_count_ff;
   logic          fixed_mirror_ff;

   // sequencer
   smmc3_pkg::seq_state_type               state_ff, state_in;
   logic [smmc3_pkg::OP_INDEX_WIDTH-1:0]   op_ff, op_in;
   logic [BW-1:0]                          res_ff [smmc3_pkg::NUM_OPERANDS];
   smmc3_pkg::flags_type                   flags_ff;

   // response register
   logic                                           rsp_valid_ff;
   logic [smmc3_pkg::PRG_SLOTS*BW-1:0]             prg_map_ff, prg_map_in;
   logic [smmc3_pkg::CHR_SLOTS*BW-1:0]             chr_map_ff, chr_map_in;
   logic                                           chr_mapped_ff;
   logic                                           mirror_h_ff;
   smmc3_pkg::flags_type                           rsp_flags_ff;

   logic                  accept;
   logic                  load_rsp;
   logic                  mod_start;
   logic                  mod_done;
   logic [BW-1:0]         mod_rem;
   logic [BW-1:0]         operand;
   logic [BW-1:0]         divisor;
   logic [BW-1:0]         bank_regs [smmc3_pkg::NUM_BANK_REGS];
   logic [BW-1:0]         select_reg;
   logic                  mirror_bit;
   smmc3_pkg::flags_type  flags;
   smmc3_pkg::item_type   item;
   logic [BW-1:0]         prg_last;
   logic [BW-1:0]         prg_slast;

   assign item     = '{func: req.func, address: req.address, data: req.data,
                       rendering_on: req.rendering_on};
   assign req.ready = (state_ff == smmc3_pkg::ST_IDLE);
   assign accept   = req.valid && req.ready;

   // csr writes, index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         prg_count_ff    <= smmc3_pkg::PRG_COUNT_RESET;
         chr_count_ff    <= '0;
         fixed_mirror_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            smmc3_pkg::CSR_PRG_COUNT:    prg_count_ff    <= csr_write_data[BW-1:0];
            smmc3_pkg::CSR_CHR_COUNT:    chr_count_ff    <= csr_write_data[BW-1:0];
            smmc3_pkg::CSR_FIXED_MIRROR: fixed_mirror_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // mapper state, updated at the accepting edge
   smmc3_state u_state (
      .clock        (clock),
      .reset        (reset),
      .apply        (accept),
      .item         (item),
      .fixed_mirror (fixed_mirror_ff),
      .bank_regs    (bank_regs),
      .select_reg   (select_reg),
      .mirror_bit   (mirror_bit),
      .flags        (flags)
   );

   // operand picked for the current reduction slot
   always_comb begin
      divisor = chr_count_ff;
      case (op_ff)
         smmc3_pkg::OP_PRG_R6: begin
            operand = bank_regs[6];
            divisor = prg_count_ff;
         end
         smmc3_pkg::OP_PRG_R7: begin
            operand = bank_regs[7];
            divisor = prg_count_ff;
         end
         smmc3_pkg::OP_CHR_LO0: operand = bank_regs[0] & smmc3_pkg::CHR_EVEN_MASK;
         smmc3_pkg::OP_CHR_LO1: operand = bank_regs[0] | smmc3_pkg::CHR_ODD_BIT;
         smmc3_pkg::OP_CHR_LO2: operand = bank_regs[1] & smmc3_pkg::CHR_EVEN_MASK;
         smmc3_pkg::OP_CHR_LO3: operand = bank_regs[1] | smmc3_pkg::CHR_ODD_BIT;
         smmc3_pkg::OP_CHR_HI0: operand = bank_regs[2];
         smmc3_pkg::OP_CHR_HI1: operand = bank_regs[3];
         smmc3_pkg::OP_CHR_HI2: operand = bank_regs[4];
         smmc3_pkg::OP_CHR_HI3: operand = bank_regs[5];
         default:               operand = '0;
      endcase
   end

   smmc3_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (operand),
      .divisor   (divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // sequencer: load operand, wait on the modulo unit, repeat, then pack
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      mod_start = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         smmc3_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = smmc3_pkg::ST_START;
               op_in    = smmc3_pkg::OP_PRG_R6;
            end
         end
         smmc3_pkg::ST_START: begin
            mod_start = 1'b1;
            state_in  = smmc3_pkg::ST_WAIT;
         end
         smmc3_pkg::ST_WAIT: begin
            if (mod_done) begin
               if (op_ff == smmc3_pkg::OP_LAST) begin
                  state_in = smmc3_pkg::ST_FINISH;
               end else begin
                  op_in    = op_ff + 1'b1;
                  state_in = smmc3_pkg::ST_START;
               end
            end
         end
         smmc3_pkg::ST_FINISH: begin
            // hold here while the previous response beat is still unclaimed
            if (!rsp_valid_ff || rsp.ready) begin
               load_rsp = 1'b1;
               state_in = smmc3_pkg::ST_IDLE;
            end
         end
         default: state_in = smmc3_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smmc3_pkg::ST_IDLE;
         op_ff    <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         flags_ff <= flags;
      end
      if (state_ff == smmc3_pkg::ST_WAIT && mod_done) begin
         res_ff[op_ff] <= mod_rem;
      end
   end

   // fixed banks wrap at 8 bits for counts below two
   assign prg_last  = prg_count_ff - BW'(1);
   assign prg_slast = prg_count_ff - BW'(2);

   always_comb begin
      if (!select_reg[6]) begin
         prg_map_in = {prg_last, prg_slast, res_ff[smmc3_pkg::OP_PRG_R7],
                       res_ff[smmc3_pkg::OP_PRG_R6]};
      end else begin
         prg_map_in = {prg_last, res_ff[smmc3_pkg::OP_PRG_R6],
                       res_ff[smmc3_pkg::OP_PRG_R7], prg_slast};
      end
      if (chr_count_ff == '0) begin
         // pattern ram: no chr banking
         chr_map_in = '0;
      end else if (!select_reg[7]) begin
         chr_map_in = {res_ff[smmc3_pkg::OP_CHR_HI3], res_ff[smmc3_pkg::OP_CHR_HI2],
                       res_ff[smmc3_pkg::OP_CHR_HI1], res_ff[smmc3_pkg::OP_CHR_HI0],
                       res_ff[smmc3_pkg::OP_CHR_LO3], res_ff[smmc3_pkg::OP_CHR_LO2],
                       res_ff[smmc3_pkg::OP_CHR_LO1], res_ff[smmc3_pkg::OP_CHR_LO0]};
      end else begin
         chr_map_in = {res_ff[smmc3_pkg::OP_CHR_LO3], res_ff[smmc3_pkg::OP_CHR_LO2],
                       res_ff[smmc3_pkg::OP_CHR_LO1], res_ff[smmc3_pkg::OP_CHR_LO0],
                       res_ff[smmc3_pkg::OP_CHR_HI3], res_ff[smmc3_pkg::OP_CHR_HI2],
                       res_ff[smmc3_pkg::OP_CHR_HI1], res_ff[smmc3_pkg::OP_CHR_HI0]};
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         prg_map_ff    <= prg_map_in;
         chr_map_ff    <= chr_map_in;
         chr_mapped_ff <= (chr_count_ff != '0);
         mirror_h_ff   <= mirror_bit;
         rsp_flags_ff  <= flags_ff;
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.prg_map           = prg_map_ff;
   assign rsp.chr_map           = chr_map_ff;
   assign rsp.chr_mapped        = chr_mapped_ff;
   assign rsp.mirror_horizontal = mirror_h_ff;
   assign rsp.mirror_set        = rsp_flags_ff.mirror_set;
   assign rsp.irq_raise         = rsp_flags_ff.irq_raise;
   assign rsp.irq_clear         = rsp_flags_ff.irq_clear;

endmodule

FILE: verif/scrambled_mmc3_bank_mapper_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrambled_mmc3_bank_mapper_test
// drives cpu writes and scanline ticks into the mapper, predicts the bank
// maps and irq/mirroring flags of every beat, checks each response beat in order
// ----------------------------------------------------------------------------
module scrambled_mmc3_bank_mapper_test;

   // csr index with no register behind it, writes there must be dropped
   localparam logic [smmc3_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE = 2'd3;
   // bank registers that feed the program map
   localparam int BANK_R6 = 6;
   localparam int BANK_R7 = 7;
   // scrambled select: entry s sits at bits [3*s +: 3]
   localparam logic [3*smmc3_pkg::NUM_BANK_REGS-1:0] SCRAMBLE =
      {3'd4, 3'd2, 3'd7, 3'd6, 3'd5, 3'd1, 3'd3, 3'd0};
   localparam int HOLD_CYCLES  = 400;  // long receiver hold-off
   localparam int DRAIN_CYCLES = 120;  // about one beat of latency
   localparam int PHASE_BEATS  = 130;
   localparam int BW           = smmc3_pkg::BANK_WIDTH;
   localparam int AW           = smmc3_pkg::ADDR_WIDTH;

   typedef struct packed {
      logic [smmc3_pkg::PRG_SLOTS*BW-1:0] prg_map;
      logic [smmc3_pkg::CHR_SLOTS*BW-1:0] chr_map;
      logic                               chr_mapped;
      logic                               mirror_horizontal;
      logic                               mirror_set;
      logic                               irq_raise;
      logic                               irq_clear;
   } map_beat_type;

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  csr_write_enable;
   logic [smmc3_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [smmc3_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data;

   smmc3_req_if req_ch ();
   smmc3_rsp_if rsp_ch ();

   scrambled_mmc3_bank_mapper u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   // predicted mapper state and csr copy
   logic [BW-1:0] prg_count;
   logic [BW-1:0] chr_count;
   logic          fixed_mirror_q;
   logic [BW-1:0] select_q;
   logic [BW-1:0] bank_q [smmc3_pkg::NUM_BANK_REGS];
   logic          mirror_q;
   logic [BW-1:0] latch_q;
   logic [BW-1:0] counter_q;
   logic          reload_q;
   logic          irq_en_q;

   map_beat_type expected_maps [$];
   int           error_count    = 0;
   int           stall_requests = 0;
   int           stall_served   = 0;
   int           stall_left     = 0;
   logic         steady         = 1'b0;

   task automatic reset_model();
      prg_count      = smmc3_pkg::PRG_COUNT_RESET;
      chr_count      = '0;
      fixed_mirror_q = 1'b0;
      select_q       = '0;
      for (int i = 0; i < smmc3_pkg::NUM_BANK_REGS; i++)
         bank_q[i] = '0;
      bank_q[smmc3_pkg::RESET_ONE_ENTRY] = 8'd1;
      mirror_q  = 1'b0;
      latch_q   = '0;
      counter_q = '0;
      reload_q  = 1'b0;
      irq_en_q  = 1'b0;
   endtask

   function automatic logic [BW-1:0] wrap_bank(input logic [BW-1:0] v,
                                               input logic [BW-1:0] n);
      return (n == 0) ? v : v % n;
   endfunction

   // advance the state by one beat and return the maps it reports
   function automatic map_beat_type apply_beat(input smmc3_pkg::item_type it);
      map_beat_type  m;
      logic [BW-1:0] lo [4];
      logic [BW-1:0] hi [4];
      logic [BW-1:0] r6, r7, last, slast;
      m = '0;
      if (it.func == smmc3_pkg::FUNC_WRITE) begin
         if (it.address >= smmc3_pkg::BANK_WIN_LO &&
             it.address <= smmc3_pkg::BANK_WIN_HI) begin
            if (it.address[0])
               bank_q[SCRAMBLE[3*select_q[2:0] +: 3]] = it.data;
            else
               select_q = it.data;
         end else begin
            case (it.address & smmc3_pkg::ADDR_DECODE_MASK)
               smmc3_pkg::DEC_MIRROR: begin
                  mirror_q     = it.data[0];
                  m.mirror_set = !fixed_mirror_q;
               end
               smmc3_pkg::DEC_IRQ_LATCH:   latch_q  = it.data;
               smmc3_pkg::DEC_IRQ_RELOAD:  reload_q = 1'b1;
               smmc3_pkg::DEC_IRQ_DISABLE: begin
                  irq_en_q    = 1'b0;
                  m.irq_clear = 1'b1;
               end
               smmc3_pkg::DEC_IRQ_ENABLE:  irq_en_q = 1'b1;
               default: ;
            endcase
         end
      end else if (it.rendering_on) begin
         if (counter_q == 0 || reload_q)
            counter_q = latch_q;
         else
            counter_q = counter_q - 8'd1;
         m.irq_raise = (counter_q == 0) && irq_en_q;
         reload_q    = 1'b0;
      end

      // fixed banks wrap at 8 bits for tiny counts
      last  = prg_count - 8'd1;
      slast = prg_count - 8'd2;
      r6    = wrap_bank(bank_q[BANK_R6], prg_count);
      r7    = wrap_bank(bank_q[BANK_R7], prg_count);
      if (!select_q[6])
         m.prg_map = {last, slast, r7, r6};
      else
         m.prg_map = {last, r6, r7, slast};

      if (chr_count != 0) begin
         lo[0] = wrap_bank(bank_q[0] & smmc3_pkg::CHR_EVEN_MASK, chr_count);
         lo[1] = wrap_bank(bank_q[0] | smmc3_pkg::CHR_ODD_BIT, chr_count);
         lo[2] = wrap_bank(bank_q[1] & smmc3_pkg::CHR_EVEN_MASK, chr_count);
         lo[3] = wrap_bank(bank_q[1] | smmc3_pkg::CHR_ODD_BIT, chr_count);
         for (int i = 0; i < 4; i++)
            hi[i] = wrap_bank(bank_q[2+i], chr_count);
         for (int i = 0; i < 4; i++) begin
            m.chr_map[8*i +: 8]     = select_q[7] ? hi[i] : lo[i];
            m.chr_map[8*(i+4) +: 8] = select_q[7] ? lo[i] : hi[i];
         end
         m.chr_mapped = 1'b1;
      end
      m.mirror_horizontal = mirror_q;
      return m;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_beat();
      map_beat_type want;
      if (expected_maps.size() == 0) begin
         report_mismatch("response beat with no request waiting");
         return;
      end
      want = expected_maps.pop_front();
      if (rsp_ch.prg_map !== want.prg_map)
         report_mismatch($sformatf("prg_map %h, want %h", rsp_ch.prg_map, want.prg_map));
      if (rsp_ch.chr_map !== want.chr_map)
         report_mismatch($sformatf("chr_map %h, want %h", rsp_ch.chr_map, want.chr_map));
      if (rsp_ch.chr_mapped !== want.chr_mapped)
         report_mismatch($sformatf("chr_mapped %b, want %b",
                                   rsp_ch.chr_mapped, want.chr_mapped));
      if (rsp_ch.mirror_horizontal !== want.mirror_horizontal)
         report_mismatch($sformatf("mirror_horizontal %b, want %b",
                                   rsp_ch.mirror_horizontal, want.mirror_horizontal));
      if (rsp_ch.mirror_set !== want.mirror_set)
         report_mismatch($sformatf("mirror_set %b, want %b",
                                   rsp_ch.mirror_set, want.mirror_set));
      if (rsp_ch.irq_raise !== want.irq_raise)
         report_mismatch($sformatf("irq_raise %b, want %b",
                                   rsp_ch.irq_raise, want.irq_raise));
      if (rsp_ch.irq_clear !== want.irq_clear)
         report_mismatch($sformatf("irq_clear %b, want %b",
                                   rsp_ch.irq_clear, want.irq_clear));
   endtask

   // response side: random ready, long holds on request, in-order checking
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            check_beat();
         if (stall_left == 0 && stall_requests != stall_served) begin
            stall_served++;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(99) >= 16);
         end
      end
   end

   // offer one beat, keep valid high after acceptance so back-to-back beats
   // never lower and raise it in the same step
   task automatic send_beat(input smmc3_pkg::item_type it);
      if (!steady && $urandom_range(99) < 16) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 110)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.func         <= it.func;
      req_ch.address      <= it.address;
      req_ch.data         <= it.data;
      req_ch.rendering_on <= it.rendering_on;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      expected_maps.push_back(apply_beat(it));
   endtask

   task automatic cpu_write(input logic [AW-1:0] a, input logic [BW-1:0] d);
      smmc3_pkg::item_type it;
      it.func         = smmc3_pkg::FUNC_WRITE;
      it.address      = a;
      it.data         = d;
      it.rendering_on = 1'($urandom_range(1));
      send_beat(it);
   endtask

   task automatic scanline(input logic rend);
      smmc3_pkg::item_type it;
      it.func         = smmc3_pkg::FUNC_TICK;
      it.address      = 16'($urandom_range(0, 65535));
      it.data         = 8'($urandom_range(0, 255));
      it.rendering_on = rend;
      send_beat(it);
   endtask

   // sender stops and waits out every outstanding beat
   task automatic pause_for_idle();
      req_ch.valid <= 1'b0;
      while (expected_maps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [smmc3_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [smmc3_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         smmc3_pkg::CSR_PRG_COUNT:    prg_count      = value;
         smmc3_pkg::CSR_CHR_COUNT:    chr_count      = value;
         smmc3_pkg::CSR_FIXED_MIRROR: fixed_mirror_q = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_counts(input logic [7:0] pc, input logic [7:0] cc, input logic fs);
      pause_for_idle();
      write_reg(smmc3_pkg::CSR_PRG_COUNT, pc);
      write_reg(smmc3_pkg::CSR_CHR_COUNT, cc);
      // upper bits of the fixed mirroring write are don't-care
      write_reg(smmc3_pkg::CSR_FIXED_MIRROR, {7'($urandom_range(0, 127)), fs});
   endtask

   // mostly decodable writes and rendering ticks, some stray addresses
   task automatic random_beat();
      int            pick;
      logic [AW-1:0] a;
      logic [BW-1:0] d;
      pick = $urandom_range(99);
      // small values half the time so the irq counter reaches zero often
      d = $urandom_range(1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7));
      if (pick < 35) begin
         scanline($urandom_range(99) < 85);
      end else if (pick < 65) begin
         a = smmc3_pkg::BANK_WIN_LO | 16'($urandom_range(0, 16'h1FFF));
         cpu_write(a, d);
      end else if (pick < 92) begin
         a = smmc3_pkg::DEC_MIRROR + 16'($urandom_range(0, 16'h5FFF));
         cpu_write(a, d);
      end else begin
         cpu_write(16'($urandom_range(0, 65535)), d);
      end
   endtask

   // ---- tests ---------------------------------------------------------------

   // reset maps, stray write and a tick with rendering off
   task automatic test_reset_view();
      scanline(1'b0);
      cpu_write(16'h0000, 8'hFF);
   endtask

   // scrambled select into the program and pattern registers, all modes
   task automatic test_bank_select();
      set_counts(8'd8, 8'd16, 1'b0);
      cpu_write(smmc3_pkg::BANK_WIN_LO, 8'h44);  // prg mode 1, lands on R6
      cpu_write(16'h8001, 8'hFF);
      cpu_write(16'h9FFE, 8'h85);                // chr mode 1, lands on R7
      cpu_write(smmc3_pkg::BANK_WIN_HI, 8'h81);
      cpu_write(16'h8FF0, 8'hC0);                // both modes, R0
      cpu_write(16'h8FF1, 8'hFF);
      cpu_write(16'h9000, 8'h02);                // no modes, R1
      cpu_write(16'h9001, 8'h7E);
   endtask

   // mirroring, irq latch/reload/enable/disable and the counter hitting zero
   task automatic test_register_decode();
      cpu_write(smmc3_pkg::DEC_MIRROR, 8'h01);
      cpu_write(smmc3_pkg::DEC_MIRROR | 16'h0001, 8'h00);  // matches no decode
      cpu_write(smmc3_pkg::DEC_IRQ_LATCH, 8'h02);
      cpu_write(smmc3_pkg::DEC_IRQ_RELOAD, 8'h55);
      cpu_write(smmc3_pkg::DEC_IRQ_ENABLE, 8'h00);
      scanline(1'b1);
      scanline(1'b1);
      scanline(1'b1);                                      // counter at zero, irq raised
      scanline(1'b0);
      cpu_write(smmc3_pkg::DEC_IRQ_DISABLE, 8'hAA);        // disable and acknowledge
      cpu_write(16'h7FFF, 8'h00);
   endtask

   // degenerate and maximum bank counts, fixed mirroring, spare csr index
   task automatic test_count_extremes();
      set_counts(8'd0, 8'd255, 1'b1);
      write_reg(CSR_SPARE, 8'hFF);
      cpu_write(16'hBFFE, 8'h00);               // mirroring write under fixed mirroring
      scanline(1'b1);
      set_counts(8'd1, 8'd1, 1'b0);
      cpu_write(16'hFFFF, 8'h00);
      set_counts(8'd255, 8'd248, 1'b0);
      cpu_write(16'hDFFE, 8'h03);
   endtask

   // several csr settings, each followed by a block of random beats
   task automatic test_random_settings();
      logic [7:0] pc, cc;
      logic       fs;
      for (int p = 0; p < 7; p++) begin
         case (p)
            0: begin pc = smmc3_pkg::PRG_COUNT_RESET; cc = 8'd0; fs = 1'b0; end
            1: begin pc = 8'd16;  cc = 8'd128; fs = 1'b0; end
            2: begin pc = 8'd254; cc = 8'd248; fs = 1'b1; end
            3: begin pc = 8'd0;   cc = 8'd255; fs = 1'b0; end
            4: begin pc = 8'd1;   cc = 8'd1;   fs = 1'b1; end
            5: begin
               pc = 8'($urandom_range(2, 254));
               cc = 8'($urandom_range(0, 248));
               fs = 1'($urandom_range(1));
            end
            default: begin pc = 8'd255; cc = 8'd0; fs = 1'b1; end
         endcase
         set_counts(pc, cc, fs);
         if (p == 3)
            write_reg(CSR_SPARE, 8'($urandom_range(0, 255)));
         repeat (PHASE_BEATS) random_beat();
      end
   endtask

   // receiver holds off while the sender keeps offering, input must stall
   task automatic test_receiver_hold();
      pause_for_idle();
      stall_requests++;
      repeat (20) random_beat();
   endtask

   // a stretch with no idling on either side
   task automatic test_back_to_back();
      steady = 1'b1;
      repeat (60) random_beat();
      steady = 1'b0;
   endtask

   initial begin
      reset_model();
      reset               <= 1'b1;
      csr_write_enable    <= 1'b0;
      csr_index           <= '0;
      csr_write_data      <= '0;
      req_ch.valid        <= 1'b0;
      req_ch.func         <= smmc3_pkg::FUNC_WRITE;
      req_ch.address      <= '0;
      req_ch.data         <= '0;
      req_ch.rendering_on <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_view();
      test_bank_select();
      test_register_decode();
      test_count_extremes();
      test_random_settings();
      test_receiver_hold();
      test_back_to_back();

      // all beats in, wait for the tail and catch any stray responses
      req_ch.valid <= 1'b0;
      while (expected_maps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // hang guard, several times the slowest legal run
   initial begin
      #12_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
